[design/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check that is switched off while reset is high.
`define CHK_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Clocked check on the cycle that follows the condition.
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/mdht_pkg.sv]
`timescale 1ns / 1ps
// Package for the motion debounce and hold timer: request and result types,
// poller state, register indexes and LED event codes. Depends on nothing.
package mdht_pkg;

   localparam logic [31:0] DEBOUNCE_MS   = 32'd50;
   localparam int unsigned MS_PER_SECOND = 1000;
   localparam int unsigned HOLD_MS_W     = 18;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_SEND    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_SECONDS = 1'd1;

   localparam logic [1:0] LED_NONE  = 2'd0;
   localparam logic [1:0] LED_RED   = 2'd1;
   localparam logic [1:0] LED_GREEN = 2'd2;

   typedef struct packed {
      logic        pin_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       sensed;
      logic       report_valid;
      logic [1:0] led_event;
   } rsp_type;

   typedef struct packed {
      logic        last_raw;
      logic        stable_level;
      logic        debounce_busy;
      logic [31:0] change_stamp;
      logic        hold_running;
      logic [31:0] hold_start;
      logic        sensed_value;
   } state_type;

endpackage

[design/motion_debounce_hold_timer.sv]
`timescale 1ns / 1ps
// Motion sensor debouncer with a retriggerable off-delay, one result per poll.
// A request is registered in the stage, then its result in the output register.
// Throughput: one request per cycle unless rsp_stall holds a pending result.
// Reset: synchronous, active high; state clears, auto_send returns to 1.
// Depends on mdht_pkg and mdht_step.
module motion_debounce_hold_timer
   import mdht_pkg::*;
#(
   parameter int unsigned DEBOUNCE_TIME_MS = DEBOUNCE_MS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   logic       stg_valid_ff, stg_valid_in;
   req_type    stg_data_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff;
   state_type  state_ff, state_in;
   rsp_type    step_result;
   logic       auto_send_ff;
   logic [7:0] keep_seconds_ff;
   logic       out_free, advance, accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = stg_valid_ff && out_free;
   assign req_stall = stg_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   mdht_step #(
      .DEBOUNCE_TIME_MS (DEBOUNCE_TIME_MS)
   ) u_step (
      .st           (state_ff),
      .item         (stg_data_ff),
      .auto_send    (auto_send_ff),
      .keep_seconds (keep_seconds_ff),
      .st_next      (state_in),
      .result       (step_result)
   );

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_send_ff    <= 1'b1;
         keep_seconds_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_AUTO_SEND:    auto_send_ff    <= csr_wdata[0];
            CSR_KEEP_SECONDS: keep_seconds_ff <= csr_wdata;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[design/mdht_step.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one poll of the debouncer and hold timer.
// Purely combinational; depends on mdht_pkg.
module mdht_step
   import mdht_pkg::*;
#(
   parameter int unsigned DEBOUNCE_TIME_MS = DEBOUNCE_MS
)
(
   input  state_type  st,
   input  req_type    item,
   input  logic       auto_send,
   input  logic [7:0] keep_seconds,
   output state_type  st_next,
   output rsp_type    result
);

   logic [HOLD_MS_W-1:0] hold_ms;
   logic [31:0]          deb_diff;
   logic [31:0]          hold_diff;
   logic [1:0]           led;
   logic                 report;

   assign hold_ms  = HOLD_MS_W'(keep_seconds) * HOLD_MS_W'(MS_PER_SECOND);
   assign deb_diff = item.now_ms - st.change_stamp;

   always_comb begin
      st_next   = st;
      led       = LED_NONE;
      report    = 1'b0;
      hold_diff = '0;
      if (item.pin_level != st.last_raw) begin
         st_next.debounce_busy = 1'b1;
         st_next.change_stamp  = item.now_ms;
         st_next.last_raw      = item.pin_level;
      end else begin
         if (st.debounce_busy && (deb_diff >= 32'(DEBOUNCE_TIME_MS))) begin
            if (item.pin_level != st.stable_level) begin
               st_next.stable_level = item.pin_level;
               st_next.sensed_value = item.pin_level;
               if (item.pin_level) begin
                  led                  = LED_GREEN;
                  st_next.hold_running = 1'b0;
                  report               = auto_send;
               end else begin
                  st_next.hold_start   = item.now_ms;
                  st_next.hold_running = 1'b1;
               end
            end
            st_next.debounce_busy = 1'b0;
         end
         hold_diff = item.now_ms - st_next.hold_start;
         if (st_next.hold_running && (hold_diff >= {{(32-HOLD_MS_W){1'b0}}, hold_ms})) begin
            led                  = LED_RED;
            st_next.sensed_value = 1'b0;
            report               = auto_send;
            st_next.hold_running = 1'b0;
         end
      end
   end

   assign result.sensed       = st_next.sensed_value;
   assign result.report_valid = report;
   assign result.led_event    = led;

endmodule

[design/mdht_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for motion_debounce_hold_timer and its bind statement.
// Depends on mdht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mdht_checker
   import mdht_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `CHK_IMPLY(a_led_code, clock, reset, rsp_valid, rsp_data.led_event != 2'd3, "bad LED code")
   `CHK_IMPLY(a_green_sensed, clock, reset, rsp_valid && (rsp_data.led_event == LED_GREEN), rsp_data.sensed, "green event without sensed")
   `CHK_IMPLY(a_red_clear, clock, reset, rsp_valid && (rsp_data.led_event == LED_RED), !rsp_data.sensed, "red event with sensed set")
   `CHK_IMPLY(a_report_event, clock, reset, rsp_valid && rsp_data.report_valid, rsp_data.led_event != LED_NONE, "report without event")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind motion_debounce_hold_timer mdht_checker u_mdht_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
